[src/i2cee_pkg.sv]
// Shared types, codes and constants of the I2C EEPROM byte access sequencer.
`default_nettype none
package i2cee_pkg;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_RESP  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      CMD_START = 3'd0,
      CMD_SEND  = 3'd1,
      CMD_RECV  = 3'd2,
      CMD_STOP  = 3'd3,
      CMD_DONE  = 3'd4
   } cmd_type;

   localparam logic [7:0] DEV_ADDR_RESET = 8'hA0;
   localparam logic [7:0] READ_BIT       = 8'h01;

   // Result queue size; two slots must be free to take a request word.
   localparam int QDEPTH  = 4;
   localparam int QADDR_W = $clog2(QDEPTH);

   typedef struct packed {
      cmd_type    command;
      logic [7:0] bus_byte;
      logic [7:0] read_data;
      logic       failed;
      logic       last;
   } result_type;

   // What one input word produces: zero, one or two results.
   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } step_type;

   function automatic result_type make_result(cmd_type cmd, logic [7:0] bus_byte,
                                              logic [7:0] read_data, logic failed,
                                              logic last);
      result_type r;
      r.command   = cmd;
      r.bus_byte  = bus_byte;
      r.read_data = read_data;
      r.failed    = failed;
      r.last      = last;
      return r;
   endfunction

endpackage
`default_nettype wire

[src/i2cee_seq.sv]
// Access state machine: holds the request, the device address and the phase.
`default_nettype none
module i2cee_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_fire,
   input  wire logic [1:0]           kind,
   input  wire logic [15:0]          mem_address,
   input  wire logic [7:0]           write_data,
   input  wire logic                 ack_missing,
   input  wire logic [7:0]           received_byte,
   input  wire logic                 csr_fire,
   input  wire logic [7:0]           csr_data,
   output i2cee_pkg::step_type       step
);

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_DEV  = 3'd1,
      PH_HIGH = 3'd2,
      PH_LOW  = 3'd3,
      PH_DATA = 3'd4,
      PH_RDEV = 3'd5,
      PH_RECV = 3'd6
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        is_write_ff, is_write_in;
   logic [15:0] held_address_ff, held_address_in;
   logic [7:0]  held_data_ff, held_data_in;
   logic [7:0]  device_address_ff;
   i2cee_pkg::kind_type kind_code;

   assign kind_code = i2cee_pkg::kind_type'(kind);

   always_comb begin
      phase_in        = phase_ff;
      is_write_in     = is_write_ff;
      held_address_in = held_address_ff;
      held_data_in    = held_data_ff;
      step            = '0;
      if ((kind_code == i2cee_pkg::KIND_READ) || (kind_code == i2cee_pkg::KIND_WRITE)) begin
         // A request is only taken when no access is in flight.
         if (phase_ff == PH_IDLE) begin
            is_write_in     = (kind_code == i2cee_pkg::KIND_WRITE);
            held_address_in = mem_address;
            held_data_in    = (kind_code == i2cee_pkg::KIND_WRITE) ? write_data : 8'h00;
            step.count = 2'd2;
            step.res0  = i2cee_pkg::make_result(i2cee_pkg::CMD_START, 8'h00, 8'h00,
                                                1'b0, 1'b0);
            step.res1  = i2cee_pkg::make_result(i2cee_pkg::CMD_SEND, device_address_ff,
                                                8'h00, 1'b0, 1'b1);
            phase_in   = PH_DEV;
         end
      end else if ((kind_code == i2cee_pkg::KIND_RESP) && (phase_ff != PH_IDLE)) begin
         if ((phase_ff == PH_RECV) || ack_missing ||
             (phase_ff == PH_DATA)) begin
            // Stop and report; the receive response carries the read byte.
            step.count = 2'd2;
            step.res0  = i2cee_pkg::make_result(i2cee_pkg::CMD_STOP, 8'h00, 8'h00,
                                                1'b0, 1'b0);
            if (phase_ff == PH_RECV) begin
               step.res1 = i2cee_pkg::make_result(i2cee_pkg::CMD_DONE, 8'h00,
                                                  received_byte, 1'b0, 1'b1);
            end else begin
               step.res1 = i2cee_pkg::make_result(i2cee_pkg::CMD_DONE, 8'h00, 8'h00,
                                                  ack_missing, 1'b1);
            end
            phase_in = PH_IDLE;
         end else begin
            case (phase_ff)
               PH_DEV: begin
                  step.count = 2'd1;
                  step.res0  = i2cee_pkg::make_result(i2cee_pkg::CMD_SEND,
                                                      held_address_ff[15:8], 8'h00,
                                                      1'b0, 1'b1);
                  phase_in   = PH_HIGH;
               end
               PH_HIGH: begin
                  step.count = 2'd1;
                  step.res0  = i2cee_pkg::make_result(i2cee_pkg::CMD_SEND,
                                                      held_address_ff[7:0], 8'h00,
                                                      1'b0, 1'b1);
                  phase_in   = PH_LOW;
               end
               PH_LOW: begin
                  if (is_write_ff) begin
                     step.count = 2'd1;
                     step.res0  = i2cee_pkg::make_result(i2cee_pkg::CMD_SEND,
                                                         held_data_ff, 8'h00,
                                                         1'b0, 1'b1);
                     phase_in   = PH_DATA;
                  end else begin
                     // Repeated start, then the device address in read form.
                     step.count = 2'd2;
                     step.res0  = i2cee_pkg::make_result(i2cee_pkg::CMD_START, 8'h00,
                                                         8'h00, 1'b0, 1'b0);
                     step.res1  = i2cee_pkg::make_result(i2cee_pkg::CMD_SEND,
                                                         device_address_ff |
                                                         i2cee_pkg::READ_BIT,
                                                         8'h00, 1'b0, 1'b1);
                     phase_in   = PH_RDEV;
                  end
               end
               PH_RDEV: begin
                  step.count = 2'd1;
                  step.res0  = i2cee_pkg::make_result(i2cee_pkg::CMD_RECV, 8'h00,
                                                      8'h00, 1'b0, 1'b1);
                  phase_in   = PH_RECV;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         is_write_ff       <= 1'b0;
         held_address_ff   <= 16'h0000;
         held_data_ff      <= 8'h00;
         device_address_ff <= i2cee_pkg::DEV_ADDR_RESET;
      end else begin
         if (in_fire) begin
            phase_ff        <= phase_in;
            is_write_ff     <= is_write_in;
            held_address_ff <= held_address_in;
            held_data_ff    <= held_data_in;
         end
         if (csr_fire) begin
            device_address_ff <= csr_data;
         end
      end
   end

endmodule
`default_nettype wire

[src/i2cee_rspq.sv]
// Result queue: takes up to two results per cycle and hands out one per cycle while pop_ready is high.
`default_nettype none
module i2cee_rspq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push_en,
   input  wire i2cee_pkg::step_type           push,
   input  wire logic                          pop_ready,
   output logic                               pop_valid,
   output i2cee_pkg::result_type              pop_data,
   output logic                               room_two,
   output logic [i2cee_pkg::QADDR_W:0]        level
);

   i2cee_pkg::result_type                 slot_ff [i2cee_pkg::QDEPTH];
   logic [i2cee_pkg::QADDR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [i2cee_pkg::QADDR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [i2cee_pkg::QADDR_W:0]           level_ff, level_in;
   logic [1:0]                            push_count;
   logic                                  pop_fire;
   logic [i2cee_pkg::QADDR_W-1:0]         wr_next;

   assign push_count = push_en ? push.count : 2'd0;
   assign pop_fire   = pop_valid && pop_ready;
   assign wr_next    = wr_ptr_ff + 1'b1;

   assign pop_valid = (level_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign room_two  = (level_ff <= (i2cee_pkg::QADDR_W + 1)'(i2cee_pkg::QDEPTH - 2));
   assign level     = level_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + i2cee_pkg::QADDR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + i2cee_pkg::QADDR_W'(pop_fire);
      level_in  = level_ff + (i2cee_pkg::QADDR_W + 1)'(push_count)
                  - (i2cee_pkg::QADDR_W + 1)'(pop_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.res0;
      end
      if (push_count == 2'd2) begin
         slot_ff[wr_next] <= push.res1;
      end
   end

endmodule
`default_nettype wire

[src/i2c_eeprom_byte_access_sequencer.sv]
// Top level of the I2C EEPROM byte access sequencer.
//
// The req_ channel carries read and write requests and the bus responses of
// the byte-level I2C master. Each accepted word updates the access state in
// the same cycle and yields zero, one or two command words on the rsp_
// channel (start, send byte, receive, stop, finished); rsp_last marks the
// final word that an input caused.
// Result words are registered in the result queue before they appear on rsp_;
// they leave one per cycle while rsp_ready is high, so an input that yields
// two results hands them out one after the other. A four-entry result queue
// sits between the sides: req_ready is high while at least two entries are
// free. Input is taken every cycle while results leave as fast as they
// arrive; once a backlog builds, a word that yields two results stalls the
// input until an entry drains. While the receiver stalls, input is taken
// until three or more entries are occupied. The csr_ channel writes the
// device address (write form); it is always ready. The user must see that it
// is written only while no access is in flight; the block does not enforce it.
// Reset is synchronous: it empties the queue, returns the sequencer to idle
// and sets the device address to 0xA0.
`default_nettype none
module i2c_eeprom_byte_access_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [15:0] req_mem_address,
   input  wire logic [7:0]  req_write_data,
   input  wire logic        req_ack_missing,
   input  wire logic [7:0]  req_received_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_command,
   output logic [7:0]       rsp_bus_byte,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_failed,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_device_address
);

   logic                              req_fire;
   i2cee_pkg::step_type               step;
   i2cee_pkg::result_type             head;
   logic [i2cee_pkg::QADDR_W:0]       level;

   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   i2cee_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .in_fire       (req_fire),
      .kind          (req_kind),
      .mem_address   (req_mem_address),
      .write_data    (req_write_data),
      .ack_missing   (req_ack_missing),
      .received_byte (req_received_byte),
      .csr_fire      (csr_valid && csr_ready),
      .csr_data      (csr_device_address),
      .step          (step)
   );

   i2cee_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push_en   (req_fire),
      .push      (step),
      .pop_ready (rsp_ready),
      .pop_valid (rsp_valid),
      .pop_data  (head),
      .room_two  (req_ready),
      .level     (level)
   );

   assign rsp_command   = head.command;
   assign rsp_bus_byte  = head.bus_byte;
   assign rsp_read_data = head.read_data;
   assign rsp_failed    = head.failed;
   assign rsp_last      = head.last;

`ifndef SYNTHESIS
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= (i2cee_pkg::QADDR_W + 1)'(i2cee_pkg::QDEPTH))
      else $error("result queue overfilled");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_command == i2cee_pkg::CMD_DONE)) |-> rsp_last)
      else $error("finished word without last");

   a_failed_only_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_failed) |-> (rsp_command == i2cee_pkg::CMD_DONE))
      else $error("failure flag on a bus command");

   a_stop_then_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && (rsp_command == i2cee_pkg::CMD_STOP)) |=>
      (rsp_valid && (rsp_command == i2cee_pkg::CMD_DONE)))
      else $error("stop not followed by finished word");
`endif

endmodule
`default_nettype wire

[tb/i2c_eeprom_byte_access_sequencer_test.sv]
// Self-checking testbench for the I2C EEPROM byte access sequencer.
`default_nettype none
module i2c_eeprom_byte_access_sequencer_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int WORDS_PER_SETTING = 200;
   localparam int SETTING_COUNT = 5;

   typedef enum logic [3:0] {
      SEQ_IDLE, SEQ_DEV, SEQ_HIGH, SEQ_LOW, SEQ_DATA, SEQ_RDEV, SEQ_RECV
   } seq_state_type;

   typedef struct packed {
      i2cee_pkg::kind_type kind;
      logic [15:0]         addr;
      logic [7:0]          wdata;
      logic                nack;
      logic [7:0]          rbyte;
   } req_word_type;

   typedef struct packed {
      req_word_type        word;
      logic                typed;
      i2cee_pkg::step_type want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_kind;
   logic [15:0] req_mem_address;
   logic [7:0]  req_write_data;
   logic        req_ack_missing;
   logic [7:0]  req_received_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_command;
   logic [7:0]  rsp_bus_byte;
   logic [7:0]  rsp_read_data;
   logic        rsp_failed;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_device_address;

   // Predicted sequencer state and register.
   seq_state_type seq_state = SEQ_IDLE;
   logic          seq_is_write = 1'b0;
   logic [15:0]   seq_address = '0;
   logic [7:0]    seq_data = '0;
   logic [7:0]    dev_address = i2cee_pkg::DEV_ADDR_RESET;

   i2cee_pkg::result_type expected_cmds[$];
   row_type               directed_rows[$];

   bit calm = 1'b0;
   int n_errors = 0;
   int n_words = 0;
   int n_effective = 0;
   int n_requests = 0;
   int n_responses = 0;
   int n_checked = 0;
   int n_failed_accesses = 0;
   int n_settings = 0;
   int idle_cycles = 0;

   i2c_eeprom_byte_access_sequencer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_mem_address    (req_mem_address),
      .req_write_data     (req_write_data),
      .req_ack_missing    (req_ack_missing),
      .req_received_byte  (req_received_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_command        (rsp_command),
      .rsp_bus_byte       (rsp_bus_byte),
      .rsp_read_data      (rsp_read_data),
      .rsp_failed         (rsp_failed),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_device_address (csr_device_address)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic i2cee_pkg::result_type cmd_word(i2cee_pkg::cmd_type cmd,
                                                      logic [7:0] bus_byte,
                                                      logic [7:0] read_data,
                                                      logic failed, logic last);
      i2cee_pkg::result_type r;
      r.command   = cmd;
      r.bus_byte  = bus_byte;
      r.read_data = read_data;
      r.failed    = failed;
      r.last      = last;
      return r;
   endfunction

   function automatic i2cee_pkg::step_type step1(i2cee_pkg::result_type r0);
      i2cee_pkg::step_type s;
      s = '0;
      s.count = 2'd1;
      s.res0  = r0;
      return s;
   endfunction

   function automatic i2cee_pkg::step_type step2(i2cee_pkg::result_type r0,
                                                 i2cee_pkg::result_type r1);
      i2cee_pkg::step_type s;
      s = '0;
      s.count = 2'd2;
      s.res0  = r0;
      s.res1  = r1;
      return s;
   endfunction

   // Stop followed by the finished word that carries the outcome.
   function automatic i2cee_pkg::step_type closing(logic [7:0] read_data, logic failed);
      return step2(cmd_word(i2cee_pkg::CMD_STOP, 8'h00, 8'h00, 1'b0, 1'b0),
                   cmd_word(i2cee_pkg::CMD_DONE, 8'h00, read_data, failed, 1'b1));
   endfunction

   // Start followed by the device address byte.
   function automatic i2cee_pkg::step_type opening(logic [7:0] address);
      return step2(cmd_word(i2cee_pkg::CMD_START, 8'h00, 8'h00, 1'b0, 1'b0),
                   cmd_word(i2cee_pkg::CMD_SEND, address, 8'h00, 1'b0, 1'b1));
   endfunction

   function automatic i2cee_pkg::step_type sending(logic [7:0] value);
      return step1(cmd_word(i2cee_pkg::CMD_SEND, value, 8'h00, 1'b0, 1'b1));
   endfunction

   // Advances the predicted sequencer by one input word and returns its results.
   function automatic i2cee_pkg::step_type advance_sequencer(req_word_type w);
      i2cee_pkg::step_type s;
      s = '0;
      case (w.kind)
         i2cee_pkg::KIND_READ, i2cee_pkg::KIND_WRITE: begin
            if (seq_state == SEQ_IDLE) begin
               seq_is_write = (w.kind == i2cee_pkg::KIND_WRITE);
               seq_address  = w.addr;
               seq_data     = seq_is_write ? w.wdata : 8'h00;
               s = opening(dev_address);
               seq_state = SEQ_DEV;
            end
         end
         i2cee_pkg::KIND_RESP: begin
            if (seq_state == SEQ_RECV) begin
               // The block answers the received byte itself, so the ack flag is moot.
               s = closing(w.rbyte, 1'b0);
               seq_state = SEQ_IDLE;
            end else if (seq_state != SEQ_IDLE && w.nack) begin
               s = closing(8'h00, 1'b1);
               seq_state = SEQ_IDLE;
            end else begin
               case (seq_state)
                  SEQ_DEV: begin
                     s = sending(seq_address[15:8]);
                     seq_state = SEQ_HIGH;
                  end
                  SEQ_HIGH: begin
                     s = sending(seq_address[7:0]);
                     seq_state = SEQ_LOW;
                  end
                  SEQ_LOW: begin
                     if (seq_is_write) begin
                        s = sending(seq_data);
                        seq_state = SEQ_DATA;
                     end else begin
                        s = opening(dev_address | i2cee_pkg::READ_BIT);
                        seq_state = SEQ_RDEV;
                     end
                  end
                  SEQ_DATA: begin
                     s = closing(8'h00, 1'b0);
                     seq_state = SEQ_IDLE;
                  end
                  SEQ_RDEV: begin
                     s = step1(cmd_word(i2cee_pkg::CMD_RECV, 8'h00, 8'h00, 1'b0, 1'b1));
                     seq_state = SEQ_RECV;
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      return s;
   endfunction

   function automatic req_word_type rq(i2cee_pkg::kind_type k, logic [15:0] a,
                                       logic [7:0] d, logic n, logic [7:0] b);
      req_word_type w;
      w.kind  = k;
      w.addr  = a;
      w.wdata = d;
      w.nack  = n;
      w.rbyte = b;
      return w;
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Mostly well-formed accesses; some words arrive out of place or carry kind 3.
   function automatic req_word_type random_word();
      req_word_type w;
      int pick;
      pick    = $urandom_range(0, 99);
      w.addr  = 16'($urandom);
      w.wdata = 8'($urandom);
      w.rbyte = 8'($urandom);
      w.nack  = ($urandom_range(0, 15) == 0);
      if (seq_state == SEQ_IDLE) begin
         if (pick < 88)
            w.kind = i2cee_pkg::kind_type'($urandom_range(0, 1));
         else if (pick < 94)
            w.kind = i2cee_pkg::KIND_RESP;
         else
            w.kind = i2cee_pkg::KIND_NONE;
      end else begin
         if (pick < 90)
            w.kind = i2cee_pkg::KIND_RESP;
         else if (pick < 96)
            w.kind = i2cee_pkg::kind_type'($urandom_range(0, 1));
         else
            w.kind = i2cee_pkg::KIND_NONE;
         if (seq_state == SEQ_RECV)
            w.nack = 1'($urandom_range(0, 1));
      end
      return w;
   endfunction

   task automatic add_row(req_word_type w, logic typed, i2cee_pkg::step_type want);
      row_type r;
      r.word  = w;
      r.typed = typed;
      r.want  = want;
      directed_rows.push_back(r);
   endtask

   // Drives one word, waits for it to be taken and records what it should cause.
   task automatic drive_word(req_word_type w, logic typed, i2cee_pkg::step_type want);
      int gap;
      i2cee_pkg::step_type s;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= w.kind;
      req_mem_address   <= w.addr;
      req_write_data    <= w.wdata;
      req_ack_missing   <= w.nack;
      req_received_byte <= w.rbyte;
      do @(posedge clock); while (!req_ready);
      s = advance_sequencer(w);
      if (typed)
         s = want;
      n_words++;
      if (s.count != 0)
         n_effective++;
      if (w.kind == i2cee_pkg::KIND_READ || w.kind == i2cee_pkg::KIND_WRITE)
         n_requests++;
      if (w.kind == i2cee_pkg::KIND_RESP)
         n_responses++;
      if (s.count >= 1)
         expected_cmds.push_back(s.res0);
      if (s.count == 2) begin
         expected_cmds.push_back(s.res1);
         if (s.res1.command == i2cee_pkg::CMD_DONE && s.res1.failed)
            n_failed_accesses++;
      end
   endtask

   // Answers the access in flight until the sequencer is idle again.
   task automatic close_access();
      while (seq_state != SEQ_IDLE)
         drive_word(rq(i2cee_pkg::KIND_RESP, 16'($urandom), 8'($urandom),
                       $urandom_range(0, 7) == 0, 8'($urandom)),
                    1'b0, '0);
   endtask

   // Takes the last word off the input and waits until every result is out.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_cmds.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_device_address(logic [7:0] value);
      @(negedge clock);
      csr_valid          <= 1'b1;
      csr_device_address <= value;
      do @(posedge clock); while (!csr_ready);
      dev_address = value;
      n_settings++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         n_errors++;
      end
   endtask

   always @(posedge clock) begin
      i2cee_pkg::result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_cmds.size() == 0) begin
               $display("%0t: result word with none expected, expected nothing, got %0d",
                        $time, rsp_command);
               n_errors++;
            end else begin
               want = expected_cmds.pop_front();
               n_checked++;
               check_field("command", 8'(want.command), 8'(rsp_command));
               check_field("bus_byte", want.bus_byte, rsp_bus_byte);
               check_field("read_data", want.read_data, rsp_read_data);
               check_field("failed", 8'(want.failed), 8'(rsp_failed));
               check_field("last", 8'(want.last), 8'(rsp_last));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_cmds.size());
            $display("[i2c_eeprom_byte_access_sequencer] ERROR");
            $finish;
         end
      end
   end

   initial begin
      int gap;
      int run;
      rsp_ready = 1'b0;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         run = $urandom_range(1, 20);
         repeat (run) @(negedge clock);
      end
   end

   initial begin
      int start;
      logic [7:0] setting;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_kind           = i2cee_pkg::KIND_NONE;
      req_mem_address    = '0;
      req_write_data     = '0;
      req_ack_missing    = 1'b0;
      req_received_byte  = '0;
      csr_valid          = 1'b0;
      csr_device_address = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Device address still at its reset value for the directed rows.
      add_row(rq(i2cee_pkg::KIND_RESP, 16'h0000, 8'h00, 1'b0, 8'h00), 1'b1, '0);
      add_row(rq(i2cee_pkg::KIND_NONE, 16'hFFFF, 8'hFF, 1'b1, 8'hFF), 1'b1, '0);
      add_row(rq(i2cee_pkg::KIND_WRITE, 16'hFFFF, 8'hFF, 1'b0, 8'h00), 1'b1,
              opening(8'hA0));
      add_row(rq(i2cee_pkg::KIND_READ, 16'h0000, 8'h00, 1'b0, 8'h00), 1'b1, '0);
      add_row(rq(i2cee_pkg::KIND_NONE, 16'h0000, 8'h00, 1'b0, 8'h00), 1'b1, '0);
      add_row(rq(i2cee_pkg::KIND_RESP, 16'h0000, 8'h00, 1'b0, 8'hFF), 1'b1,
              sending(8'hFF));
      add_row(rq(i2cee_pkg::KIND_RESP, 16'h0000, 8'h00, 1'b0, 8'h00), 1'b1,
              sending(8'hFF));
      add_row(rq(i2cee_pkg::KIND_RESP, 16'h0000, 8'h00, 1'b0, 8'h00), 1'b1,
              sending(8'hFF));
      add_row(rq(i2cee_pkg::KIND_RESP, 16'h0000, 8'h00, 1'b0, 8'h00), 1'b1,
              closing(8'h00, 1'b0));
      add_row(rq(i2cee_pkg::KIND_READ, 16'h0000, 8'hFF, 1'b0, 8'h00), 1'b1,
              opening(8'hA0));
      add_row(rq(i2cee_pkg::KIND_RESP, 16'h0000, 8'h00, 1'b0, 8'h00), 1'b1,
              sending(8'h00));
      add_row(rq(i2cee_pkg::KIND_RESP, 16'h0000, 8'h00, 1'b0, 8'h00), 1'b1,
              sending(8'h00));
      add_row(rq(i2cee_pkg::KIND_RESP, 16'h0000, 8'h00, 1'b0, 8'h00), 1'b1,
              opening(8'hA1));
      add_row(rq(i2cee_pkg::KIND_RESP, 16'h0000, 8'h00, 1'b0, 8'h00), 1'b1,
              step1(cmd_word(i2cee_pkg::CMD_RECV, 8'h00, 8'h00, 1'b0, 1'b1)));
      add_row(rq(i2cee_pkg::KIND_RESP, 16'h0000, 8'h00, 1'b1, 8'hFF), 1'b1,
              closing(8'hFF, 1'b0));
      add_row(rq(i2cee_pkg::KIND_READ, 16'h1234, 8'h00, 1'b0, 8'h00), 1'b0, '0);
      add_row(rq(i2cee_pkg::KIND_RESP, 16'h0000, 8'h00, 1'b1, 8'h00), 1'b1,
              closing(8'h00, 1'b1));
      add_row(rq(i2cee_pkg::KIND_WRITE, 16'hA5C3, 8'h5A, 1'b0, 8'h00), 1'b0, '0);
      add_row(rq(i2cee_pkg::KIND_RESP, 16'h0000, 8'h00, 1'b0, 8'h00), 1'b0, '0);
      add_row(rq(i2cee_pkg::KIND_RESP, 16'h0000, 8'h00, 1'b0, 8'h00), 1'b0, '0);
      add_row(rq(i2cee_pkg::KIND_RESP, 16'h0000, 8'h00, 1'b1, 8'h00), 1'b1,
              closing(8'h00, 1'b1));
      add_row(rq(i2cee_pkg::KIND_READ, 16'h00FF, 8'h00, 1'b0, 8'h00), 1'b0, '0);
      add_row(rq(i2cee_pkg::KIND_RESP, 16'h0000, 8'h00, 1'b0, 8'h00), 1'b0, '0);
      add_row(rq(i2cee_pkg::KIND_RESP, 16'h0000, 8'h00, 1'b0, 8'h00), 1'b0, '0);
      add_row(rq(i2cee_pkg::KIND_RESP, 16'h0000, 8'h00, 1'b0, 8'h00), 1'b0, '0);
      add_row(rq(i2cee_pkg::KIND_RESP, 16'h0000, 8'h00, 1'b1, 8'h00), 1'b1,
              closing(8'h00, 1'b1));

      foreach (directed_rows[i])
         drive_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
      close_access();

      for (int p = 0; p < SETTING_COUNT; p++) begin
         // The register is only rewritten once the last access has fully drained.
         wait_drained();
         setting = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom);
         write_device_address(setting);
         calm = (p == 2);
         start = n_effective;
         while (n_effective - start < WORDS_PER_SETTING)
            drive_word(random_word(), 1'b0, '0);
         close_access();
      end
      calm = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_cmds.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d words: %0d requests, %0d bus responses, %0d with no effect.",
               n_words, n_requests, n_responses, n_words - n_effective);
      $display("Checked %0d result words, %0d failed accesses, %0d device address settings.",
               n_checked, n_failed_accesses, n_settings);
      if (n_errors == 0)
         $display("[i2c_eeprom_byte_access_sequencer] OK");
      else
         $display("[i2c_eeprom_byte_access_sequencer] ERROR");
      $finish;
   end

endmodule
`default_nettype wire
